[hw/rtl/ols_pkg.sv]
// Shared types and codes for the ordered list store.
package ols_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_DELETE     = 2'd2;
    localparam logic [1:0] CMD_DUMP       = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic               last;
    } t_out_item;

    // Decoded command as handed from the front end to the executor.
    typedef struct packed {
        logic               insert;
        logic               at_front;
        logic               remove;
        logic               dump;
        logic signed [31:0] value;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

endpackage

[hw/rtl/ols_front.sv]
// Front end: accepts items, decodes them and queues them for the executor.
module ols_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ols_pkg::t_in_item i_cmd_item,
    output logic              busy,
    output ols_pkg::t_job_req o_req,
    input  logic              i_take
);

    ols_pkg::t_job                     r_q [ols_pkg::QUEUE_DEPTH];
    logic [ols_pkg::QPTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [ols_pkg::QCNT_W-1:0]        r_cnt;
    logic                              push, pop;
    ols_pkg::t_job                     dec;

    always_comb begin
        dec          = '0;
        dec.value    = i_cmd_item.data_value;
        case (i_cmd_item.cmd)
            ols_pkg::CMD_PUSH_FRONT: begin
                dec.insert   = 1'b1;
                dec.at_front = 1'b1;
            end
            ols_pkg::CMD_PUSH_BACK: dec.insert = 1'b1;
            ols_pkg::CMD_DELETE:    dec.remove = 1'b1;
            default:                dec.dump   = 1'b1;
        endcase
    end

    assign busy  = (r_cnt == ols_pkg::QCNT_W'(ols_pkg::QUEUE_DEPTH));
    assign push  = start && !busy;
    assign pop   = i_take && (r_cnt != '0);
    assign o_req = '{valid: (r_cnt != '0), job: r_q[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == ols_pkg::QPTR_W'(ols_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == ols_pkg::QPTR_W'(ols_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

[hw/rtl/ols_back.sv]
// Executor: keeps the list in a circular buffer memory and runs each command.
module ols_back #(
    parameter int LIST_DEPTH = ols_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ols_pkg::t_job_req  i_req,
    output logic               o_take,
    output logic               o_result_valid,
    output ols_pkg::t_out_item o_result
);

    localparam int PTR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DOUT = 3'd6;

    logic signed [31:0]  r_mem [LIST_DEPTH];
    logic signed [31:0]  r_rd_data;

    logic [2:0]          r_state, n_state;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic signed [31:0]  r_key, n_key;
    logic                r_out_valid, n_out_valid;
    ols_pkg::t_out_item  r_out, n_out;

    logic                we;
    logic [PTR_W-1:0]    wr_addr, rd_addr;
    logic signed [31:0]  wr_data;
    logic [CNT_W:0]      idx_p1, idx_p2;

    // Logical position to physical slot: head + pos wraps at most once.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(LIST_DEPTH)) begin
            sum = sum - (PTR_W+1)'(LIST_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign idx_p1 = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign idx_p2 = {1'b0, r_idx} + (CNT_W+1)'(2);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_out_valid = 1'b0;
        n_out       = '{status: ols_pkg::ST_OK, entry_value: '0, last: 1'b1};
        o_take      = 1'b0;
        we          = 1'b0;
        wr_addr     = phys(r_head, r_idx[PTR_W-1:0]);
        wr_data     = r_rd_data;
        rd_addr     = phys(r_head, r_idx[PTR_W-1:0]);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    o_take = 1'b1;
                    n_idx  = '0;
                    n_key  = i_req.job.value;
                    if (i_req.job.insert) begin
                        n_out_valid = 1'b1;
                        if (r_count == CNT_W'(LIST_DEPTH)) begin
                            n_out.status = ols_pkg::ST_FULL;
                        end else begin
                            we      = 1'b1;
                            wr_data = i_req.job.value;
                            n_count = r_count + 1'b1;
                            if (i_req.job.at_front) begin
                                n_head  = (r_head == '0) ? PTR_W'(LIST_DEPTH - 1)
                                                         : r_head - 1'b1;
                                wr_addr = n_head;
                            end else begin
                                wr_addr = phys(r_head, r_count[PTR_W-1:0]);
                            end
                        end
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ols_pkg::ST_EMPTY;
                    end else if (i_req.job.remove) begin
                        n_state = S_SRD;
                    end else begin
                        n_state = S_DRD;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_rd_data == r_key) begin
                    if (idx_p1 < {1'b0, r_count}) begin
                        n_state = S_MRD;
                    end else begin
                        n_count     = r_count - 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (idx_p1 == {1'b0, r_count}) begin
                    n_out_valid  = 1'b1;
                    n_out.status = ols_pkg::ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                rd_addr = phys(r_head, idx_p1[PTR_W-1:0]);
                n_state = S_MWR;
            end
            S_MWR: begin
                // close the gap: entry idx takes what sat at idx + 1
                we = 1'b1;
                if (idx_p2 < {1'b0, r_count}) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_MRD;
                end else begin
                    n_count     = r_count - 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                n_out_valid       = 1'b1;
                n_out.entry_value = r_rd_data;
                n_out.last        = (idx_p1 == {1'b0, r_count});
                if (n_out.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

[hw/rtl/ordered_list_store_top.sv]
// Ordered list store: top level joining the command front end and the executor.
//
// Commands are taken whenever busy is low; a two-item queue lets a few commands
// wait while the executor works. Results appear for one cycle with
// o_result_valid and cannot be held off, so the receiver must take each one
// as it comes. Push front and push back are done in the idle state as the
// command is taken. Delete reads and compares one entry at a time (one memory
// read port) in S_SRD and S_SCMP, and then moves each later entry down
// through S_MRD and S_MWR. Dump reads each entry in S_DRD and gives it out in
// S_DOUT. An empty list or a full insert is answered straight from the idle
// state. The list lives in a LIST_DEPTH-entry memory with one write and one
// registered read port; no clearing pass is needed after reset.
module ordered_list_store_top #(
    parameter int LIST_DEPTH = ols_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ols_pkg::t_in_item  i_cmd_item,
    output logic               busy,
    output logic               o_result_valid,
    output ols_pkg::t_out_item o_result
);

    ols_pkg::t_job_req req;
    logic              take;

    ols_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd_item (i_cmd_item),
        .busy       (busy),
        .o_req      (req),
        .i_take     (take)
    );

    ols_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .o_take         (take),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

[tb/ordered_list_store_top_tb.sv]
// Self-checking testbench for the ordered list store: directed and random commands.
module ordered_list_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ols_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 64;
    localparam int RANDOM_ITEMS = 260;

    // Two copies of the list: one tracks what the DUT holds, one plans stimulus.
    localparam int MDL_DUT  = 0;
    localparam int MDL_PLAN = 1;

    localparam int SEQ_FILL  = 0;
    localparam int SEQ_DRAIN = 1;
    localparam int SEQ_MIX   = 2;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  cmd_item = '0;
    logic      busy;
    logic      res_valid;
    t_out_item res;

    t_in_item           cmd_backlog[$];
    t_out_item          due_results[$];
    logic signed [31:0] list_mem[2][LIST_DEPTH];
    int                 list_cnt[2] = '{0, 0};
    int                 mismatch_cnt = 0;
    logic               took = 1'b0;
    int                 burst_left = 1;
    int                 gap_left = 0;

    ordered_list_store_top #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_cmd_item(cmd_item),
        .busy(busy),
        .o_result_valid(res_valid),
        .o_result(res)
    );

    always #5 i_clk = ~i_clk;

    // Apply one command to list copy m; for the DUT copy, queue the results it owes.
    function automatic void list_apply(input int m, input t_in_item it);
        int        n;
        int        hit;
        t_out_item r;
        n = list_cnt[m];
        hit = -1;
        r.status = ST_OK;
        r.entry_value = '0;
        r.last = 1'b1;
        case (it.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (n >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.cmd == CMD_PUSH_FRONT) begin
                        for (int i = n; i > 0; i--) list_mem[m][i] = list_mem[m][i-1];
                        list_mem[m][0] = it.data_value;
                    end else begin
                        list_mem[m][n] = it.data_value;
                    end
                    list_cnt[m] = n + 1;
                end
            end
            CMD_DELETE: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && list_mem[m][i] == it.data_value) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        for (int i = hit; i < n - 1; i++) list_mem[m][i] = list_mem[m][i+1];
                        list_cnt[m] = n - 1;
                    end
                end
            end
            default: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (m == MDL_DUT) begin
                        for (int i = 0; i < n; i++) begin
                            r.entry_value = list_mem[m][i];
                            r.last = (i == n - 1);
                            due_results.push_back(r);
                        end
                    end
                    return;
                end
            end
        endcase
        if (m == MDL_DUT) due_results.push_back(r);
    endfunction

    // Mix of corner values, a small range that makes duplicates, and full random.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $signed($urandom_range(8)) - 4;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic plan(input logic [1:0] cmd, input logic signed [31:0] val);
        t_in_item it;
        it.cmd = cmd;
        it.data_value = val;
        list_apply(MDL_PLAN, it);
        cmd_backlog.push_back(it);
    endtask

    // Check results first so a command taken this edge never meets an older result.
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
        if (i_rst_n && res_valid) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d entry_value %0d last %0b",
                       res.status, res.entry_value, res.last);
                mismatch_cnt++;
            end else begin
                if (res.status !== due_results[0].status) begin
                    $error("status: expected %0d, actual %0d",
                           due_results[0].status, res.status);
                    mismatch_cnt++;
                end
                if (res.entry_value !== due_results[0].entry_value) begin
                    $error("entry_value: expected %0d, actual %0d",
                           due_results[0].entry_value, res.entry_value);
                    mismatch_cnt++;
                end
                if (res.last !== due_results[0].last) begin
                    $error("last: expected %0b, actual %0b",
                           due_results[0].last, res.last);
                    mismatch_cnt++;
                end
                void'(due_results.pop_front());
            end
        end
        if (i_rst_n && start && !busy) list_apply(MDL_DUT, cmd_item);
    end

    // Sender: bursts of items with random gaps; holds an item until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (took) void'(cmd_backlog.pop_front());
            if (start && !took) begin
                // still waiting on busy
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() > 0) begin
                start <= 1'b1;
                cmd_item <= cmd_backlog[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        int seq_len;
        int seq_mode;
        int roll;
        int rnd_cnt;
        logic [1:0] cmd;
        logic signed [31:0] val;

        // Directed: empty cases, extreme values, every command, not found.
        plan(CMD_DUMP, $signed($urandom));
        plan(CMD_DELETE, 32'sd5);
        plan(CMD_PUSH_BACK, 32'sh7fff_ffff);
        plan(CMD_PUSH_FRONT, 32'sh8000_0000);
        plan(CMD_PUSH_BACK, 32'sd0);
        plan(CMD_PUSH_FRONT, -32'sd1);
        plan(CMD_DUMP, $signed($urandom));
        plan(CMD_DELETE, 32'sd1234);
        plan(CMD_DELETE, 32'sd0);
        plan(CMD_DELETE, -32'sd1);
        plan(CMD_PUSH_BACK, 32'sh7fff_ffff);
        plan(CMD_DELETE, 32'sh7fff_ffff);
        plan(CMD_DUMP, $signed($urandom));
        plan(CMD_DELETE, 32'sh8000_0000);
        plan(CMD_DELETE, 32'sh7fff_ffff);
        plan(CMD_DUMP, $signed($urandom));
        plan(CMD_PUSH_FRONT, 32'sh5555_5555);
        plan(CMD_PUSH_BACK, 32'shaaaa_aaaa);
        plan(CMD_DUMP, $signed($urandom));

        // Random: fill runs (first one is long enough to overflow the list), drain runs, and noise.
        rnd_cnt = 0;
        while (rnd_cnt < RANDOM_ITEMS) begin
            if (rnd_cnt == 0) begin
                seq_mode = SEQ_FILL;
                seq_len = LIST_DEPTH + 4;
            end else begin
                seq_mode = $urandom_range(2);
                seq_len = $urandom_range(5, 40);
            end
            for (int k = 0; k < seq_len && rnd_cnt < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(99);
                val = pick_value();
                case (seq_mode)
                    SEQ_FILL: begin
                        if (roll < 45) cmd = CMD_PUSH_FRONT;
                        else if (roll < 90) cmd = CMD_PUSH_BACK;
                        else if (roll < 95) cmd = CMD_DELETE;
                        else cmd = CMD_DUMP;
                    end
                    SEQ_DRAIN: begin
                        if (roll < 80) cmd = CMD_DELETE;
                        else if (roll < 90) cmd = CMD_DUMP;
                        else cmd = ($urandom_range(1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                        // mostly delete a value that is really in the list
                        if (roll < 65 && list_cnt[MDL_PLAN] > 0)
                            val = list_mem[MDL_PLAN][$urandom_range(list_cnt[MDL_PLAN] - 1)];
                    end
                    default: cmd = 2'($urandom_range(3));
                endcase
                plan(cmd, val);
                rnd_cnt++;
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || start) @(negedge i_clk);
        while (due_results.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ols_pkg.sv
hw/rtl/ols_front.sv
hw/rtl/ols_back.sv
hw/rtl/ordered_list_store_top.sv
tb/ordered_list_store_top_tb.sv
